// ===== rtl/core/ffba_pkg.sv =====
// ffba_pkg: shared widths, defaults and codes of the first-fit block allocator.
// No dependencies; used by ffba_ram and first_fit_block_allocator.
`default_nettype none

package ffba_pkg;

  localparam int POOL_BLOCKS_DEF = 256;
  localparam int REC_W           = 9;
  localparam int BS_W            = 17;
  localparam int REQ_W           = 24;
  localparam int IDX_W           = 8;
  localparam int STAT_W          = 2;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = 17'd64;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_BADINDEX = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffba_ram.sv =====
// ffba_ram: generic simple dual-port RAM, one write port, one registered read port.
// Defaults from ffba_pkg.
`default_nettype none

module ffba_ram #(
  parameter int  WIDTH = ffba_pkg::REC_W,
  parameter int  DEPTH = ffba_pkg::POOL_BLOCKS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_block_allocator.sv =====
// first_fit_block_allocator: first-fit allocator over a pool of fixed-size blocks.
// Run-length records live in one ffba_ram; uses ffba_pkg for widths and codes.
//
//  channel | dir | handshake          | word
//  s_      | in  | s_tvalid/s_tready  | tdata: request_bytes, free_index; tuser: action
//  m_      | out | m_tvalid/m_tready  | tdata: head_index; tuser: status
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data: block_size_bytes
//
// Free: the accepted word goes to S_FREE, which writes the record, then to S_DONE.
// Allocate: one RAM read per scan step in S_HEAD and S_RUN; each step waits on the RAM read port.
// Reset: a clearing pass writes every record to zero, with s_tready low; config
// writes are taken throughout.
// One item at a time; a new word is taken while a result waits in the output register.
`default_nettype none

module first_fit_block_allocator #(
  parameter int POOL_BLOCKS = ffba_pkg::POOL_BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [31:0]                 s_tdata,   // [23:0] request_bytes, [31:24] free_index
  input  wire logic                        s_tuser,   // [0] action
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,   // [7:0] head_index
  output logic [ffba_pkg::STAT_W-1:0]      m_tuser,   // [1:0] status
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ffba_pkg::BS_W-1:0]   cfg_data
);

  localparam int ADDR_W = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int KW     = ADDR_W + 1;
  localparam int CNT_W  = $clog2(POOL_BLOCKS + (1 << ffba_pkg::REC_W));
  localparam int RW     = KW + ffba_pkg::BS_W;
  localparam int CMP_W  = (RW > ffba_pkg::REQ_W + 1) ? RW : ffba_pkg::REQ_W + 1;
  localparam int REC_W  = ffba_pkg::REC_W;
  localparam int REQ_W  = ffba_pkg::REQ_W;
  localparam int IDX_W  = ffba_pkg::IDX_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HEAD  = 6'b000100,
    S_RUN   = 6'b001000,
    S_FREE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                    state, state_next;
  logic [ADDR_W-1:0]         clr_cnt;
  logic [ffba_pkg::BS_W-1:0] blk_size;
  logic [REQ_W-1:0]          req, req_next;
  logic [IDX_W-1:0]          fidx, fidx_next;
  logic [CNT_W-1:0]          pos, pos_next;
  logic [KW-1:0]             k, k_next;
  logic [REQ_W-1:0]          acc, acc_next;
  ffba_pkg::status_t         res_status, res_status_next;
  logic [IDX_W-1:0]          res_head, res_head_next;
  logic                      out_valid;
  ffba_pkg::status_t         out_status;
  logic [IDX_W-1:0]          out_head;

  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [REC_W-1:0]          wdata;
  logic [CNT_W-1:0]          rd_wide;
  logic                      rd_issue;
  logic [REC_W-1:0]          q;

  logic [ffba_pkg::BS_W-1:0] bs_eff;
  logic [KW-1:0]             rem_blocks;
  logic [RW-1:0]             rem_bytes;
  logic                      rem_fits;
  logic [REQ_W:0]            acc_sum;
  logic                      step_hit;
  logic [CNT_W-1:0]          head_jump;
  logic [CNT_W-1:0]          pos_k;
  logic [CNT_W-1:0]          run_jump;
  logic [CNT_W-1:0]          pos_inc;
  logic [CNT_W-1:0]          pos_k_inc;
  logic                      slot_free;
  logic                      in_take;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_head;
  assign m_tuser   = out_status;
  assign in_take   = s_tvalid && s_tready;
  assign slot_free = !out_valid || m_tready;

  assign bs_eff     = (blk_size == '0) ? ffba_pkg::BS_W'(1) : blk_size;
  assign rem_blocks = KW'(POOL_BLOCKS) - KW'(pos);
  assign rem_bytes  = RW'(rem_blocks) * RW'(bs_eff);
  assign rem_fits   = CMP_W'(rem_bytes) > CMP_W'(req);
  assign acc_sum    = {1'b0, acc} + (REQ_W + 1)'(bs_eff);
  assign step_hit   = acc_sum >= {1'b0, req};
  assign head_jump  = pos + CNT_W'(q);
  assign pos_k      = pos + CNT_W'(k);
  assign run_jump   = pos_k + CNT_W'(q);
  assign pos_inc    = pos + CNT_W'(1);
  assign pos_k_inc  = pos_k + CNT_W'(1);

  ffba_ram #(
    .WIDTH (REC_W),
    .DEPTH (POOL_BLOCKS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ADDR_W'(rd_wide)),
    .rdata (q)
  );

  always_comb begin
    state_next      = state;
    req_next        = req;
    fidx_next       = fidx;
    pos_next        = pos;
    k_next          = k;
    acc_next        = acc;
    res_status_next = res_status;
    res_head_next   = res_head;
    we              = 1'b0;
    waddr           = '0;
    wdata           = '0;
    rd_wide         = '0;
    rd_issue        = 1'b0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        if (clr_cnt == ADDR_W'(POOL_BLOCKS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          req_next  = s_tdata[REQ_W-1:0];
          fidx_next = s_tdata[31:24];
          pos_next  = '0;
          k_next    = '0;
          acc_next  = '0;
          if (s_tuser == ffba_pkg::ACT_FREE) begin
            state_next = S_FREE;
          end else begin
            rd_wide    = '0;
            rd_issue   = 1'b1;
            state_next = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (q != '0) begin
          pos_next = head_jump;
          if (head_jump < CNT_W'(POOL_BLOCKS)) begin
            rd_wide  = head_jump;
            rd_issue = 1'b1;
          end else begin
            res_status_next = ffba_pkg::ST_NOSPACE;
            res_head_next   = '0;
            state_next      = S_DONE;
          end
        end else if (rem_fits) begin
          if (req == '0 || step_hit) begin
            we              = 1'b1;
            waddr           = ADDR_W'(pos);
            wdata           = (req == '0) ? REC_W'(0) : REC_W'(1);
            res_status_next = ffba_pkg::ST_OK;
            res_head_next   = IDX_W'(pos);
            state_next      = S_DONE;
          end else begin
            k_next     = KW'(1);
            acc_next   = acc_sum[REQ_W-1:0];
            rd_wide    = pos_inc;
            rd_issue   = 1'b1;
            state_next = S_RUN;
          end
        end else begin
          pos_next = pos_inc;
          if (pos_inc < CNT_W'(POOL_BLOCKS)) begin
            rd_wide  = pos_inc;
            rd_issue = 1'b1;
          end else begin
            res_status_next = ffba_pkg::ST_NOSPACE;
            res_head_next   = '0;
            state_next      = S_DONE;
          end
        end
      end
      S_RUN: begin
        if (q != '0) begin
          pos_next = run_jump;
          k_next   = '0;
          acc_next = '0;
          if (run_jump < CNT_W'(POOL_BLOCKS)) begin
            rd_wide    = run_jump;
            rd_issue   = 1'b1;
            state_next = S_HEAD;
          end else begin
            res_status_next = ffba_pkg::ST_NOSPACE;
            res_head_next   = '0;
            state_next      = S_DONE;
          end
        end else if (step_hit) begin
          we              = 1'b1;
          waddr           = ADDR_W'(pos);
          wdata           = REC_W'(k + KW'(1));
          res_status_next = ffba_pkg::ST_OK;
          res_head_next   = IDX_W'(pos);
          state_next      = S_DONE;
        end else begin
          k_next   = k + KW'(1);
          acc_next = acc_sum[REQ_W-1:0];
          rd_wide  = pos_k_inc;
          rd_issue = 1'b1;
        end
      end
      S_FREE: begin
        res_head_next = '0;
        if (32'(fidx) < 32'(POOL_BLOCKS)) begin
          we              = 1'b1;
          waddr           = ADDR_W'(fidx);
          res_status_next = ffba_pkg::ST_OK;
        end else begin
          res_status_next = ffba_pkg::ST_BADINDEX;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      blk_size  <= ffba_pkg::BLOCK_SIZE_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        blk_size <= cfg_data;
      end
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    fidx       <= fidx_next;
    pos        <= pos_next;
    k          <= k_next;
    acc        <= acc_next;
    res_status <= res_status_next;
    res_head   <= res_head_next;
    if (state == S_DONE && slot_free) begin
      out_status <= res_status;
      out_head   <= res_head;
    end
  end

  a_rd_in_pool: assert property (@(posedge clk) disable iff (rst)
    rd_issue |-> rd_wide < CNT_W'(POOL_BLOCKS))
    else $error("record read beyond pool");

  a_fail_head_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ffba_pkg::ST_OK |-> m_tdata == '0)
    else $error("nonzero head on failed word");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !s_tready)
    else $error("second word taken while busy");

  a_no_write_while_scanning: assert property (@(posedge clk) disable iff (rst)
    we && (state == S_HEAD || state == S_RUN) |-> state_next == S_DONE)
    else $error("record write in mid-scan");

endmodule

`default_nettype wire
